[hw/rtl/prvag_pkg.sv]
// ----------------------------------------------------------------------------
// prvag_pkg
// Shared widths, constants, register indexes and types for the peak / RMS
// voice activity gate.
// ----------------------------------------------------------------------------
`default_nettype none

package prvag_pkg;

	localparam int DEF_MAX_CHANNELS = 8;
	localparam int DEF_MAX_FRAMES   = 8192;

	localparam int LEVEL_W    = 15;
	localparam int PCT_W      = 7;
	localparam int SUM_W      = 48;
	localparam int SQ_W       = 30;
	localparam int ROOT_W     = 24;
	localparam int SQRT_REM_W = 26;
	localparam int PCT_PROD_W = 22;
	localparam int CNT_W      = 6;
	localparam int MS_W       = 32;

	localparam int DIV_STEPS  = 48;
	localparam int SQRT_STEPS = 24;
	localparam int PCT_STEPS  = 7;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 15'h7ffe;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 15'h7fff;
	localparam int                 MS_PER_S   = 1000;

	localparam int THR_W     = 7;
	localparam int LAG_W     = 20;
	localparam int SPLIT_W   = 20;
	localparam int CHCNT_W   = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FADEOUT_LAG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_ENABLE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_SEC    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS     = 3'd4;

	localparam logic [THR_W-1:0]   RST_THRESHOLD = 7'd2;
	localparam logic [LAG_W-1:0]   RST_LAG       = 20'd500;
	localparam logic [CHCNT_W-1:0] RST_CHANNELS  = 4'd1;

	typedef struct packed {
		logic               done;
		logic [LEVEL_W-1:0] peak;
		logic [LEVEL_W-1:0] rms;
		logic [PCT_W-1:0]   ppct;
		logic [PCT_W-1:0]   rpct;
	} level_res_t;

endpackage

`default_nettype wire

[hw/rtl/peak_rms_voice_activity_gate.sv]
// ----------------------------------------------------------------------------
// peak_rms_voice_activity_gate
// Per-block peak and RMS level detector with loudness gate, fadeout hangover
// and file open / split-close flags.
//
//   channel   handshake            payload
//   in        in_valid / in_stall  opcode, sample, last_of_block
//   out       out_valid/ out_stall peak_level .. close_file (one per block)
//   cfg       cfg_we               cfg_index, cfg_data
//
// A tick is taken in ST_IDLE; a sample is registered as abs and square,
// then added with saturation. A block-end sample runs the shared subtract
// unit: 48 division steps, 24 square-root steps, 2 x 7 percent steps, plus
// start and finish, and the finish waits for a free output register.
// Reset is asynchronous and needs no clearing pass. in_stall is high from
// the cycle after an accepted sample until its work is done.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_rms_voice_activity_gate
	import prvag_pkg::*;
#(
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	parameter int MAX_FRAMES   = DEF_MAX_FRAMES
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 opcode,
	input  wire logic signed [15:0]   sample,
	input  wire logic                 last_of_block,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [LEVEL_W-1:0]        peak_level,
	output logic [LEVEL_W-1:0]        rms_level,
	output logic [PCT_W-1:0]          peak_percent,
	output logic [PCT_W-1:0]          rms_percent,
	output logic                      loud,
	output logic                      record_block,
	output logic                      open_file,
	output logic                      close_file,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int FR_W = $clog2(MAX_FRAMES + 1);
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CP_W = CH_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_START,
		ST_WAIT
	} gate_state_t;

	gate_state_t          state_q;
	logic [THR_W-1:0]     thr_q;
	logic [LAG_W-1:0]     lag_q;
	logic                 split_en_q;
	logic [SPLIT_W-1:0]   split_s_q;
	logic [CHCNT_W-1:0]   chcnt_q;
	logic [MS_W-1:0]      split_limit_q;

	logic [SUM_W-1:0]     sum_q;
	logic [LEVEL_W-1:0]   peak_q;
	logic [CH_W-1:0]      pos_q;
	logic [FR_W-1:0]      frame_q;
	logic [MS_W-1:0]      ms_q;
	logic                 file_q;
	logic [LEVEL_W-1:0]   mag_q;
	logic [SQ_W-1:0]      sq_q;
	logic                 last_q;

	logic                 out_valid_q;
	logic [LEVEL_W-1:0]   peak_level_q;
	logic [LEVEL_W-1:0]   rms_level_q;
	logic [PCT_W-1:0]     peak_pct_q;
	logic [PCT_W-1:0]     rms_pct_q;
	logic                 loud_q;
	logic                 rec_q;
	logic                 open_q;
	logic                 close_q;

	logic                 in_acc;
	logic [15:0]          neg;
	logic [LEVEL_W-1:0]   mag;
	logic [SUM_W:0]       sum_add;
	logic [4:0]           ch_used5;
	logic [CP_W-1:0]      pos_inc;
	logic [FR_W-1:0]      frames_eff;
	level_res_t           res;
	logic                 finish;
	logic                 is_loud;
	logic [MS_W-1:0]      ms_nx;
	logic                 rec;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	assign neg = 16'(~sample + 16'sd1);
	assign mag = sample[15] ? (neg[15] ? LEVEL_MAX : neg[LEVEL_W-1:0])
	                        : sample[LEVEL_W-1:0];

	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(sq_q);

	always_comb begin
		if (chcnt_q == '0) begin
			ch_used5 = 5'd1;
		end else if ({1'b0, chcnt_q} > 5'(MAX_CHANNELS)) begin
			ch_used5 = 5'(MAX_CHANNELS);
		end else begin
			ch_used5 = {1'b0, chcnt_q};
		end
	end

	assign pos_inc    = {1'b0, pos_q} + CP_W'(1);
	assign frames_eff = (frame_q == '0) ? FR_W'(1) : frame_q;

	prvag_level_calc #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.sum    (sum_q),
		.frames (frames_eff),
		.peak   (peak_q),
		.res    (res)
	);

	assign finish  = (state_q == ST_WAIT) && res.done && (!out_valid_q || !out_stall);
	assign is_loud = res.ppct > thr_q;
	assign ms_nx   = is_loud ? '0 : ms_q;
	assign rec     = ms_nx < MS_W'(lag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			thr_q         <= RST_THRESHOLD;
			lag_q         <= RST_LAG;
			split_en_q    <= 1'b0;
			split_s_q     <= '0;
			chcnt_q       <= RST_CHANNELS;
			split_limit_q <= MS_W'(MS_PER_S);
			sum_q         <= '0;
			peak_q        <= '0;
			pos_q         <= '0;
			frame_q       <= '0;
			ms_q          <= '1;
			file_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			split_limit_q <= MS_W'((MS_W'(split_s_q) + MS_W'(1)) * MS_W'(MS_PER_S));

			if (cfg_we) begin
				case (cfg_index)
					CFG_THRESHOLD:    thr_q      <= cfg_data[THR_W-1:0];
					CFG_FADEOUT_LAG:  lag_q      <= cfg_data[LAG_W-1:0];
					CFG_SPLIT_ENABLE: split_en_q <= cfg_data[0];
					CFG_SPLIT_SEC:    split_s_q  <= cfg_data[SPLIT_W-1:0];
					CFG_CHANNELS:     chcnt_q    <= cfg_data[CHCNT_W-1:0];
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (opcode) begin
							if (ms_q != '1) begin
								ms_q <= ms_q + MS_W'(1);
							end
						end else begin
							mag_q   <= mag;
							sq_q    <= SQ_W'(mag) * SQ_W'(mag);
							last_q  <= last_of_block;
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					if (mag_q > peak_q) begin
						peak_q <= mag_q;
					end
					sum_q <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
					if (pos_q == '0 && frame_q < FR_W'(MAX_FRAMES)) begin
						frame_q <= frame_q + FR_W'(1);
					end
					pos_q   <= (pos_inc >= ch_used5[CH_W:0]) ? '0 : pos_inc[CH_W-1:0];
					state_q <= last_q ? ST_START : ST_IDLE;
				end
				ST_START: begin
					sum_q   <= '0;
					peak_q  <= '0;
					pos_q   <= '0;
					frame_q <= '0;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (finish) begin
						ms_q         <= ms_nx;
						out_valid_q  <= 1'b1;
						peak_level_q <= res.peak;
						rms_level_q  <= res.rms;
						peak_pct_q   <= res.ppct;
						rms_pct_q    <= res.rpct;
						loud_q       <= is_loud;
						rec_q        <= rec;
						open_q       <= rec && !file_q;
						close_q      <= 1'b0;
						if (rec) begin
							file_q <= 1'b1;
						end else if (file_q && split_en_q && ms_nx >= split_limit_q) begin
							close_q <= 1'b1;
							file_q  <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign peak_level   = peak_level_q;
	assign rms_level    = rms_level_q;
	assign peak_percent = peak_pct_q;
	assign rms_percent  = rms_pct_q;
	assign loud         = loud_q;
	assign record_block = rec_q;
	assign open_file    = open_q;
	assign close_file   = close_q;

endmodule

`default_nettype wire

[hw/rtl/prvag_level_calc.sv]
// ----------------------------------------------------------------------------
// prvag_level_calc
// Block-end level math on one shared compare/subtract unit: mean of squares
// by restoring division, floor square root, then peak and RMS percent.
// ----------------------------------------------------------------------------
`default_nettype none

module prvag_level_calc
	import prvag_pkg::*;
#(
	parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [SUM_W-1:0]                    sum,
	input  wire logic [$clog2(MAX_FRAMES+1)-1:0]     frames,
	input  wire logic [LEVEL_W-1:0]                  peak,
	output level_res_t                               res
);

	localparam int FR_W  = $clog2(MAX_FRAMES + 1);
	localparam int SUB_W = (FR_W + 1 > SQRT_REM_W) ? FR_W + 1 : SQRT_REM_W;

	typedef enum logic [2:0] {
		C_IDLE,
		C_DIV,
		C_SQRT,
		C_PPCT,
		C_RPCT,
		C_DONE
	} calc_state_t;

	calc_state_t          state_q;
	logic [FR_W-1:0]      divisor_q;
	logic [LEVEL_W-1:0]   peak_q;
	logic [SUM_W-1:0]     quot_q;
	logic [SUB_W-1:0]     rem_q;
	logic [ROOT_W-1:0]    root_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PCT_W-1:0]     pct_q;
	logic [LEVEL_W-1:0]   rms_q;
	logic [PCT_W-1:0]     ppct_q;
	logic [PCT_W-1:0]     rpct_q;

	logic [SUB_W-1:0]      sub_a;
	logic [SUB_W-1:0]      sub_b;
	logic [SUB_W:0]        diff;
	logic                  ge;
	logic [SUB_W-1:0]      rem_nx;
	logic [ROOT_W-1:0]     root_nx;
	logic [PCT_PROD_W-1:0] scale_sh;

	function automatic logic [PCT_PROD_W-1:0] times100(input logic [LEVEL_W-1:0] x);
		logic [PCT_PROD_W-1:0] xe;
		xe = PCT_PROD_W'(x);
		return (xe << 6) + (xe << 5) + (xe << 2);
	endfunction

	assign scale_sh = PCT_PROD_W'(FULL_SCALE) << cnt_q[2:0];
	assign root_nx  = {root_q[ROOT_W-2:0], ge};

	always_comb begin
		sub_a = rem_q;
		sub_b = '0;
		case (state_q)
			C_DIV: begin
				sub_a = SUB_W'({rem_q[SUB_W-2:0], quot_q[SUM_W-1]});
				sub_b = SUB_W'(divisor_q);
			end
			C_SQRT: begin
				sub_a = SUB_W'({rem_q[SUB_W-3:0], quot_q[SUM_W-1:SUM_W-2]});
				sub_b = SUB_W'({root_q, 2'b01});
			end
			C_PPCT, C_RPCT: begin
				sub_a = rem_q;
				sub_b = SUB_W'(scale_sh);
			end
			default: begin
				sub_a = rem_q;
				sub_b = '0;
			end
		endcase
	end

	assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign ge     = ~diff[SUB_W];
	assign rem_nx = ge ? diff[SUB_W-1:0] : sub_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			case (state_q)
				C_DIV: begin
					rem_q  <= rem_nx;
					quot_q <= {quot_q[SUM_W-2:0], ge};
					cnt_q  <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						rem_q   <= '0;
						root_q  <= '0;
						cnt_q   <= CNT_W'(SQRT_STEPS - 1);
						state_q <= C_SQRT;
					end
				end
				C_SQRT: begin
					rem_q  <= rem_nx;
					quot_q <= quot_q << 2;
					root_q <= root_nx;
					cnt_q  <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						rms_q   <= (root_nx > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX
						                                          : root_nx[LEVEL_W-1:0];
						rem_q   <= SUB_W'(times100(peak_q));
						cnt_q   <= CNT_W'(PCT_STEPS - 1);
						state_q <= C_PPCT;
					end
				end
				C_PPCT: begin
					rem_q <= rem_nx;
					pct_q <= {pct_q[PCT_W-2:0], ge};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						ppct_q  <= {pct_q[PCT_W-2:0], ge};
						rem_q   <= SUB_W'(times100(rms_q));
						cnt_q   <= CNT_W'(PCT_STEPS - 1);
						state_q <= C_RPCT;
					end
				end
				C_RPCT: begin
					rem_q <= rem_nx;
					pct_q <= {pct_q[PCT_W-2:0], ge};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						rpct_q  <= {pct_q[PCT_W-2:0], ge};
						state_q <= C_DONE;
					end
				end
				default: begin
					if (start) begin
						divisor_q <= frames;
						peak_q    <= peak;
						quot_q    <= sum;
						rem_q     <= '0;
						cnt_q     <= CNT_W'(DIV_STEPS - 1);
						state_q   <= C_DIV;
					end
				end
			endcase
		end
	end

	assign res.done = (state_q == C_DONE);
	assign res.peak = peak_q;
	assign res.rms  = rms_q;
	assign res.ppct = ppct_q;
	assign res.rpct = rpct_q;

endmodule

`default_nettype wire

[hw/rtl/prvag_checker.sv]
// ----------------------------------------------------------------------------
// prvag_checker
// Port-level checks for the voice activity gate, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prvag_checker
	import prvag_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               opcode,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [LEVEL_W-1:0] peak_level,
	input wire logic [PCT_W-1:0]   peak_percent,
	input wire logic               loud,
	input wire logic               record_block,
	input wire logic               open_file,
	input wire logic               close_file
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(peak_level))
		else $error("result item changed while stalled");

	a_open_needs_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && open_file |-> record_block)
		else $error("file open flagged on a block that is not recorded");

	a_close_not_record: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && close_file |-> !record_block && !open_file)
		else $error("file close flagged on a recorded block");

	a_tick_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode |=> !in_stall)
		else $error("tick item stalled the input");

	a_loud_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && loud |-> peak_percent != '0)
		else $error("loud block with zero peak percent");

endmodule

bind peak_rms_voice_activity_gate prvag_checker u_prvag_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.opcode       (opcode),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.peak_level   (peak_level),
	.peak_percent (peak_percent),
	.loud         (loud),
	.record_block (record_block),
	.open_file    (open_file),
	.close_file   (close_file)
);

`default_nettype wire

[verif/peak_rms_voice_activity_gate_tb.sv]
// ----------------------------------------------------------------------------
// peak_rms_voice_activity_gate_tb
// Self-checking bench for the voice activity gate. A queue of sample and
// tick items feeds a valid/stall driver, a bit-accurate level and gate
// predictor runs on every accepted item, and a monitor compares each block
// report field by field. The run steps through several register settings,
// extremes included, with random idling on both sides and one long silence
// after a loud block for the split close.
// ----------------------------------------------------------------------------
module peak_rms_voice_activity_gate_tb;
	import prvag_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	localparam int unsigned      CYCLE_LIMIT = 1_000_000;
	localparam longint unsigned  SUM_TOP     = 64'hFFFF_FFFF_FFFF;
	localparam logic [MS_W-1:0]  NEVER_LOUD  = '1;

	typedef struct {
		logic               op;
		logic signed [15:0] smp;
		logic               eob;
	} audio_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] peak;
		logic [LEVEL_W-1:0] rms;
		logic [PCT_W-1:0]   ppct;
		logic [PCT_W-1:0]   rpct;
		logic               loud;
		logic               rec;
		logic               opn;
		logic               cls;
	} block_levels_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 opcode;
	logic signed [15:0]   sample;
	logic                 last_of_block;
	logic                 out_valid;
	logic                 out_stall;
	logic [LEVEL_W-1:0]   peak_level;
	logic [LEVEL_W-1:0]   rms_level;
	logic [PCT_W-1:0]     peak_percent;
	logic [PCT_W-1:0]     rms_percent;
	logic                 loud;
	logic                 record_block;
	logic                 open_file;
	logic                 close_file;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	audio_item_t   pending_items[$];
	block_levels_t awaited_levels[$];
	audio_item_t   next_item;
	bit            idle_on = 1'b1;
	int unsigned   mismatches;
	int unsigned   blocks_seen;
	int unsigned   cycle_count;

	logic [THR_W-1:0]   thr_pct   = RST_THRESHOLD;
	logic [LAG_W-1:0]   lag_ms    = RST_LAG;
	logic               split_on  = 1'b0;
	logic [SPLIT_W-1:0] split_sec = '0;
	logic [CHCNT_W-1:0] chans     = RST_CHANNELS;

	longint unsigned    sum_sq    = 0;
	logic [LEVEL_W-1:0] blk_peak  = '0;
	int unsigned        ch_pos    = 0;
	int unsigned        frm_cnt   = 0;
	logic [MS_W-1:0]    ms_quiet  = NEVER_LOUD;
	logic               file_open = 1'b0;

	peak_rms_voice_activity_gate u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.sample       (sample),
		.last_of_block(last_of_block),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.peak_level   (peak_level),
		.rms_level    (rms_level),
		.peak_percent (peak_percent),
		.rms_percent  (rms_percent),
		.loud         (loud),
		.record_block (record_block),
		.open_file    (open_file),
		.close_file   (close_file),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned chans_in_use();
		if (chans == 0)
			return 1;
		if (chans > DEF_MAX_CHANNELS)
			return DEF_MAX_CHANNELS;
		return chans;
	endfunction

	task automatic track_levels(input logic op, input logic signed [15:0] smp,
			input logic eob);
		int              mag;
		longint unsigned sq;
		longint unsigned q;
		longint unsigned root;
		longint unsigned trial;
		int unsigned     frames;
		block_levels_t   lv;
		if (op == OP_TICK) begin
			if (ms_quiet != NEVER_LOUD)
				ms_quiet++;
			return;
		end
		mag = (smp < 0) ? -int'(smp) : int'(smp);
		if (mag > int'(LEVEL_MAX))
			mag = int'(LEVEL_MAX);
		if (mag > int'(blk_peak))
			blk_peak = LEVEL_W'(mag);
		sq = longint'(mag) * longint'(mag);
		if (sum_sq > SUM_TOP - sq)
			sum_sq = SUM_TOP;
		else
			sum_sq += sq;
		if (ch_pos == 0 && frm_cnt < DEF_MAX_FRAMES)
			frm_cnt++;
		ch_pos++;
		if (ch_pos >= chans_in_use())
			ch_pos = 0;
		if (!eob)
			return;

		frames = (frm_cnt != 0) ? frm_cnt : 1;
		q = sum_sq / frames;
		root = 0;
		for (int b = 23; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= q)
				root = trial;
		end
		if (root > LEVEL_MAX)
			root = LEVEL_MAX;
		lv.peak = blk_peak;
		lv.rms  = LEVEL_W'(root);
		lv.ppct = PCT_W'((int'(blk_peak) * 100) / int'(FULL_SCALE));
		lv.rpct = PCT_W'((int'(root) * 100) / int'(FULL_SCALE));
		lv.loud = lv.ppct > thr_pct;
		if (lv.loud)
			ms_quiet = '0;
		lv.rec = ms_quiet < MS_W'(lag_ms);
		lv.opn = 1'b0;
		lv.cls = 1'b0;
		if (lv.rec) begin
			lv.opn = !file_open;
			file_open = 1'b1;
		end else if (file_open && split_on && (ms_quiet / MS_PER_S) > split_sec) begin
			lv.cls = 1'b1;
			file_open = 1'b0;
		end
		awaited_levels.push_back(lv);
		sum_sq   = 0;
		blk_peak = '0;
		ch_pos   = 0;
		frm_cnt  = 0;
	endtask

	task automatic log_mismatch(input string msg);
		mismatches++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic check_block();
		block_levels_t got;
		block_levels_t want;
		string         bad;
		got = '{peak_level, rms_level, peak_percent, rms_percent,
			loud, record_block, open_file, close_file};
		blocks_seen++;
		if (awaited_levels.size() == 0) begin
			log_mismatch($sformatf("block report %0d with no block end pending", blocks_seen));
			return;
		end
		want = awaited_levels.pop_front();
		bad = "";
		if (got.peak != want.peak) bad = {bad, " peak_level"};
		if (got.rms  != want.rms)  bad = {bad, " rms_level"};
		if (got.ppct != want.ppct) bad = {bad, " peak_percent"};
		if (got.rpct != want.rpct) bad = {bad, " rms_percent"};
		if (got.loud != want.loud) bad = {bad, " loud"};
		if (got.rec  != want.rec)  bad = {bad, " record_block"};
		if (got.opn  != want.opn)  bad = {bad, " open_file"};
		if (got.cls  != want.cls)  bad = {bad, " close_file"};
		if (bad != "")
			log_mismatch($sformatf(
				"block %0d:%s | got %0d %0d %0d %0d %b%b%b%b want %0d %0d %0d %0d %b%b%b%b",
				blocks_seen, bad, got.peak, got.rms, got.ppct, got.rpct,
				got.loud, got.rec, got.opn, got.cls, want.peak, want.rms, want.ppct,
				want.rpct, want.loud, want.rec, want.opn, want.cls));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				track_levels(opcode, sample, last_of_block);
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && !(idle_on && $urandom_range(99) < 17)) begin
					next_item = pending_items.pop_front();
					in_valid      <= 1'b1;
					opcode        <= next_item.op;
					sample        <= next_item.smp;
					last_of_block <= next_item.eob;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_block();
			out_stall <= idle_on && ($urandom_range(99) < 17);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("peak_rms_voice_activity_gate_tb NOT OK");
			$finish;
		end
	end

	task automatic push_item(input logic op, input logic signed [15:0] smp,
			input logic eob);
		audio_item_t it;
		it.op  = op;
		it.smp = smp;
		it.eob = eob;
		pending_items.push_back(it);
	endtask

	function automatic logic signed [15:0] pick_sample(input bit hot);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return 16'sh8000;
		if (r == 1)
			return 16'sh7fff;
		if (hot)
			return 16'($urandom);
		if (r < 10)
			return 16'(int'($urandom_range(0, 600)) - 300);
		return 16'(int'($urandom_range(0, 2400)) - 1200);
	endfunction

	// hold until every item is taken and every report is back, then drain
	task automatic settle(input int unsigned drain);
		while (pending_items.size() != 0 || in_valid || awaited_levels.size() != 0)
			@(negedge clk);
		repeat (drain) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_THRESHOLD:    thr_pct   = val[THR_W-1:0];
			CFG_FADEOUT_LAG:  lag_ms    = val[LAG_W-1:0];
			CFG_SPLIT_ENABLE: split_on  = val[0];
			CFG_SPLIT_SEC:    split_sec = val[SPLIT_W-1:0];
			CFG_CHANNELS:     chans     = val[CHCNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [CFG_DAT_W-1:0] thr,
			input logic [CFG_DAT_W-1:0] lag, input logic [CFG_DAT_W-1:0] sen,
			input logic [CFG_DAT_W-1:0] ssec, input logic [CFG_DAT_W-1:0] ch);
		settle(16);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_FADEOUT_LAG, lag);
		write_reg(CFG_SPLIT_ENABLE, sen);
		write_reg(CFG_SPLIT_SEC, ssec);
		write_reg(CFG_CHANNELS, ch);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int unsigned budget);
		int unsigned count;
		int unsigned len;
		int unsigned n;
		bit          hot;
		count = 0;
		while (count < budget) begin
			hot = $urandom_range(99) < 40;
			if ($urandom_range(99) < 85)
				len = $urandom_range(1, 3 * chans_in_use());
			else
				len = $urandom_range(1, 64);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(99) < 10) begin
					push_item(OP_TICK, 16'($urandom), 1'($urandom));
					count++;
				end
				push_item(OP_SAMPLE, pick_sample(hot), i == len - 1);
			end
			count += len;
			if ($urandom_range(99) < 60) begin
				n = $urandom_range(0, 12);
				repeat (n) push_item(OP_TICK, 16'($urandom), 1'($urandom));
				count += n;
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		opcode        = OP_SAMPLE;
		sample        = '0;
		last_of_block = 1'b0;
		out_stall     = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_THRESHOLD;
		cfg_data      = '0;
		mismatches    = 0;
		blocks_seen   = 0;
		cycle_count   = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// tick while never loud, zero block, tiny, full scale, bit patterns,
		// threshold edges at the reset settings
		apply_settings(RST_THRESHOLD, RST_LAG, 0, 0, RST_CHANNELS);
		push_item(OP_TICK, 16'sh7fff, 1'b1);
		push_item(OP_SAMPLE, 16'sh0000, 1'b1);
		push_item(OP_SAMPLE, 16'sh0001, 1'b0);
		push_item(OP_SAMPLE, -16'sh0001, 1'b1);
		push_item(OP_SAMPLE, 16'sh8000, 1'b1);
		push_item(OP_SAMPLE, 16'sh7fff, 1'b0);
		push_item(OP_SAMPLE, 16'sh7ffe, 1'b1);
		push_item(OP_TICK, 16'sh0000, 1'b0);
		push_item(OP_TICK, 16'sh0000, 1'b0);
		push_item(OP_SAMPLE, 16'sh5555, 1'b0);
		push_item(OP_SAMPLE, 16'shaaaa, 1'b1);
		push_item(OP_SAMPLE, 16'sd982, 1'b1);
		push_item(OP_SAMPLE, -16'sd983, 1'b1);
		push_item(OP_SAMPLE, 16'sd983, 1'b1);

		apply_settings(0, 100, 1, 0, 2);
		random_phase(40);
		apply_settings(127, 0, 1, 20'hFFFFF, 0);
		random_phase(40);
		apply_settings(50, 20'hFFFFF, 0, 1000000, 15);
		random_phase(40);
		apply_settings(1, 1000, 1, 1, 8);
		random_phase(40);
		idle_on = 1'b0;
		apply_settings(10, 300, 1, 0, 3);
		random_phase(40);

		// loud block, one second of silence, then a quiet block closes the file
		push_item(OP_SAMPLE, 16'sh7fff, 1'b1);
		repeat (1000) push_item(OP_TICK, 16'sh0000, 1'b0);
		push_item(OP_SAMPLE, 16'sh0000, 1'b1);
		settle(200);

		if (mismatches == 0) begin
			$display("peak_rms_voice_activity_gate_tb OK");
		end else begin
			$display("peak_rms_voice_activity_gate_tb NOT OK");
		end
		$finish;
	end

endmodule

[peak_rms_voice_activity_gate.f]
hw/rtl/prvag_pkg.sv
hw/rtl/prvag_level_calc.sv
hw/rtl/peak_rms_voice_activity_gate.sv
hw/rtl/prvag_checker.sv
verif/peak_rms_voice_activity_gate_tb.sv
